// ----- sv/rvalu_pkg.sv -----
// ---------------------------------------------------------------------------
// rvalu_pkg
// Shared operation codes and the word type that moves down the divide chain.
// ---------------------------------------------------------------------------
package rvalu_pkg;

    localparam int XLEN      = 64;
    localparam int DIV_STEPS = XLEN;

    localparam logic [4:0] OP_ADD    = 5'd0;
    localparam logic [4:0] OP_SUB    = 5'd1;
    localparam logic [4:0] OP_AND    = 5'd2;
    localparam logic [4:0] OP_OR     = 5'd3;
    localparam logic [4:0] OP_XOR    = 5'd4;
    localparam logic [4:0] OP_SLL    = 5'd5;
    localparam logic [4:0] OP_SRL    = 5'd6;
    localparam logic [4:0] OP_SRA    = 5'd7;
    localparam logic [4:0] OP_SLT    = 5'd8;
    localparam logic [4:0] OP_SLTU   = 5'd9;
    localparam logic [4:0] OP_MUL    = 5'd10;
    localparam logic [4:0] OP_MULH   = 5'd11;
    localparam logic [4:0] OP_MULHSU = 5'd12;
    localparam logic [4:0] OP_MULHU  = 5'd13;
    localparam logic [4:0] OP_DIV    = 5'd14;
    localparam logic [4:0] OP_DIVU   = 5'd15;
    localparam logic [4:0] OP_REM    = 5'd16;
    localparam logic [4:0] OP_REMU   = 5'd17;
    localparam logic [4:0] OP_ADDW   = 5'd18;
    localparam logic [4:0] OP_SUBW   = 5'd19;
    localparam logic [4:0] OP_SLLW   = 5'd20;
    localparam logic [4:0] OP_SRLW   = 5'd21;
    localparam logic [4:0] OP_SRAW   = 5'd22;
    localparam logic [4:0] OP_MULW   = 5'd23;
    localparam logic [4:0] OP_DIVW   = 5'd24;
    localparam logic [4:0] OP_DIVUW  = 5'd25;
    localparam logic [4:0] OP_REMW   = 5'd26;
    localparam logic [4:0] OP_REMUW  = 5'd27;

    // One word in flight. Non-divide words ride along with res already final.
    typedef struct packed {
        logic            valid;
        logic            is_div;
        logic            want_rem;
        logic            neg_res;
        logic            is_w;
        logic [XLEN-1:0] rem;
        logic [XLEN-1:0] quo;
        logic [XLEN-1:0] dvsr;
        logic [XLEN-1:0] res;
    } t_div_word;

    function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] x);
        return {{(XLEN-32){x[31]}}, x[31:0]};
    endfunction

endpackage

// ----- sv/rv64im_integer_alu.sv -----
// ---------------------------------------------------------------------------
// rv64im_integer_alu
// RV64IM integer execute unit: ALU, multiplier and divider in one pipeline.
// ---------------------------------------------------------------------------
//  channel | ports                                   | direction
//  in      | i_valid o_stall i_operation i_operand_* | word in
//  out     | o_valid i_stall o_result                | word out
//
//  One word accepted per cycle while o_stall is low; every word passes through
//  decode, two multiply stages, 64 divide stages and the output register. Latency is set by
//  the divide chain, one quotient bit per stage. The whole pipe advances
//  together; o_stall is high when the output holds a word and i_stall is high.
//  Reset is synchronous and clears all valid bits.
// ---------------------------------------------------------------------------
module rv64im_integer_alu
    import rvalu_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [4:0]      i_operation,
    input  logic [XLEN-1:0] i_operand_a,
    input  logic [XLEN-1:0] i_operand_b,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [XLEN-1:0] o_result
);

    logic en;

    // pipeline stage signals
    t_div_word       n_s1, r_s1, r_s2, r_s3, n_s3, div_out;
    logic [4:0]      r_s1_op, r_s2_op;
    logic [63:0]     r_ll, r_lh, r_hl, r_hh;
    logic [XLEN-1:0] n_corr, r_s1_corr, r_s2_corr;
    logic [127:0]    r_prod;
    logic            r_out_valid;
    logic [XLEN-1:0] r_out_res;

    logic [XLEN-1:0] a, b, simple, dvd, dvs;
    logic [5:0]      sh;
    logic            is_sdiv, is_udiv, is_w_div;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_out_valid;
    assign o_result = r_out_res;

    assign a  = i_operand_a;
    assign b  = i_operand_b;
    assign sh = b[5:0];

    always_comb begin
        case (i_operation)
            OP_ADD:  simple = a + b;
            OP_SUB:  simple = a - b;
            OP_AND:  simple = a & b;
            OP_OR:   simple = a | b;
            OP_XOR:  simple = a ^ b;
            OP_SLL:  simple = a << sh;
            OP_SRL:  simple = a >> sh;
            OP_SRA:  simple = $signed(a) >>> sh;
            OP_SLT:  simple = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
            OP_SLTU: simple = {{(XLEN-1){1'b0}}, a < b};
            OP_ADDW: simple = sext32(a + b);
            OP_SUBW: simple = sext32(a - b);
            OP_SLLW: simple = sext32({32'b0, a[31:0] << sh[4:0]});
            OP_SRLW: simple = sext32({32'b0, a[31:0] >> sh[4:0]});
            OP_SRAW: simple = sext32({32'b0, $signed(a[31:0]) >>> sh[4:0]});
            default: simple = '0;
        endcase
    end

    always_comb begin
        case (i_operation)
            OP_MULH:   n_corr = (a[XLEN-1] ? b : '0) + (b[XLEN-1] ? a : '0);
            OP_MULHSU: n_corr = a[XLEN-1] ? b : '0;
            default:   n_corr = '0;
        endcase
    end

    always_comb begin
        is_sdiv  = (i_operation == OP_DIV)  || (i_operation == OP_REM) ||
                   (i_operation == OP_DIVW) || (i_operation == OP_REMW);
        is_udiv  = (i_operation == OP_DIVU)  || (i_operation == OP_REMU) ||
                   (i_operation == OP_DIVUW) || (i_operation == OP_REMUW);
        is_w_div = (i_operation == OP_DIVW)  || (i_operation == OP_REMW) ||
                   (i_operation == OP_DIVUW) || (i_operation == OP_REMUW);
        if (is_w_div && is_sdiv) begin
            dvd = sext32(a);
            dvs = sext32(b);
        end else if (is_w_div) begin
            dvd = {32'b0, a[31:0]};
            dvs = {32'b0, b[31:0]};
        end else begin
            dvd = a;
            dvs = b;
        end
        n_s1          = '0;
        n_s1.valid    = i_valid;
        n_s1.is_div   = is_sdiv || is_udiv;
        n_s1.is_w     = is_w_div;
        n_s1.want_rem = (i_operation == OP_REM)  || (i_operation == OP_REMU) ||
                        (i_operation == OP_REMW) || (i_operation == OP_REMUW);
        n_s1.res      = simple;
        n_s1.rem      = '0;
        if (is_sdiv) begin
            // quotient sign flips only for a nonzero divisor
            n_s1.neg_res = n_s1.want_rem ? dvd[XLEN-1]
                         : ((dvd[XLEN-1] ^ dvs[XLEN-1]) && (dvs != '0));
            n_s1.quo     = dvd[XLEN-1] ? -dvd : dvd;
            n_s1.dvsr    = dvs[XLEN-1] ? -dvs : dvs;
        end else begin
            n_s1.neg_res = 1'b0;
            n_s1.quo     = dvd;
            n_s1.dvsr    = dvs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (en) begin
            r_s1.valid <= n_s1.valid;
            r_s2.valid <= r_s1.valid;
            r_s3.valid <= r_s2.valid;
        end
        if (en) begin
            r_s1.is_div <= n_s1.is_div;  r_s1.want_rem <= n_s1.want_rem;
            r_s1.neg_res <= n_s1.neg_res; r_s1.is_w <= n_s1.is_w;
            r_s1.rem <= n_s1.rem; r_s1.quo <= n_s1.quo;
            r_s1.dvsr <= n_s1.dvsr; r_s1.res <= n_s1.res;
            r_s1_op   <= i_operation;
            r_s1_corr <= n_corr;
            r_ll <= a[31:0]  * b[31:0];
            r_lh <= a[31:0]  * b[63:32];
            r_hl <= a[63:32] * b[31:0];
            r_hh <= a[63:32] * b[63:32];

            r_s2.is_div <= r_s1.is_div;  r_s2.want_rem <= r_s1.want_rem;
            r_s2.neg_res <= r_s1.neg_res; r_s2.is_w <= r_s1.is_w;
            r_s2.rem <= r_s1.rem; r_s2.quo <= r_s1.quo;
            r_s2.dvsr <= r_s1.dvsr; r_s2.res <= r_s1.res;
            r_s2_op   <= r_s1_op;
            r_s2_corr <= r_s1_corr;
            r_prod    <= {r_hh, r_ll} + {32'b0, r_lh, 32'b0} + {32'b0, r_hl, 32'b0};

            r_s3.is_div <= n_s3.is_div;  r_s3.want_rem <= n_s3.want_rem;
            r_s3.neg_res <= n_s3.neg_res; r_s3.is_w <= n_s3.is_w;
            r_s3.rem <= n_s3.rem; r_s3.quo <= n_s3.quo;
            r_s3.dvsr <= n_s3.dvsr; r_s3.res <= n_s3.res;
        end
    end

    always_comb begin
        n_s3 = r_s2;
        case (r_s2_op)
            OP_MUL:    n_s3.res = r_prod[63:0];
            OP_MULH:   n_s3.res = r_prod[127:64] - r_s2_corr;
            OP_MULHSU: n_s3.res = r_prod[127:64] - r_s2_corr;
            OP_MULHU:  n_s3.res = r_prod[127:64];
            OP_MULW:   n_s3.res = sext32(r_prod[63:0]);
            default:   n_s3.res = r_s2.res;
        endcase
    end

    rvalu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_word  (r_s3),
        .o_word  (div_out)
    );

    logic [XLEN-1:0] pick, signed_pick, n_out_res;

    always_comb begin
        pick        = div_out.want_rem ? div_out.rem : div_out.quo;
        signed_pick = div_out.neg_res ? -pick : pick;
        if (!div_out.is_div) begin
            n_out_res = div_out.res;
        end else if (div_out.is_w) begin
            n_out_res = sext32(signed_pick);
        end else begin
            n_out_res = signed_pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_out.valid;
        end
        if (en) begin
            r_out_res <= n_out_res;
        end
    end

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("stall raised with empty output");
    a_accept_loads_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1.valid) else $error("accepted word lost");
    a_out_follows_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && div_out.valid) |=> o_valid) else $error("divider word dropped");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("output valid after reset");

endmodule

// ----- sv/rvalu_div.sv -----
// ---------------------------------------------------------------------------
// rvalu_div
// Restoring divider, one quotient bit per register stage, DIV_STEPS stages.
// ---------------------------------------------------------------------------
module rvalu_div
    import rvalu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_div_word i_word,
    output t_div_word o_word
);

    t_div_word r_st [DIV_STEPS+1];

    assign r_st[0] = i_word;
    assign o_word  = r_st[DIV_STEPS];

    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_step
            logic [XLEN:0]   n_trial;
            t_div_word       n_word;

            always_comb begin
                n_trial = {r_st[g].rem, r_st[g].quo[XLEN-1]} - {1'b0, r_st[g].dvsr};
                n_word  = r_st[g];
                if (!n_trial[XLEN]) begin
                    n_word.rem = n_trial[XLEN-1:0];
                end else begin
                    n_word.rem = {r_st[g].rem[XLEN-2:0], r_st[g].quo[XLEN-1]};
                end
                n_word.quo = {r_st[g].quo[XLEN-2:0], ~n_trial[XLEN]};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_st[g+1].valid <= 1'b0;
                end else if (i_en) begin
                    r_st[g+1].valid <= n_word.valid;
                end
                if (i_en) begin
                    r_st[g+1].is_div   <= n_word.is_div;
                    r_st[g+1].want_rem <= n_word.want_rem;
                    r_st[g+1].neg_res  <= n_word.neg_res;
                    r_st[g+1].is_w     <= n_word.is_w;
                    r_st[g+1].rem      <= n_word.rem;
                    r_st[g+1].quo      <= n_word.quo;
                    r_st[g+1].dvsr     <= n_word.dvsr;
                    r_st[g+1].res      <= n_word.res;
                end
            end
        end
    endgenerate

endmodule

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the RV64IM integer execute unit: directed corner operands for
// many operations and the unused codes, then bursty random words with random output stall and a long output hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import rvalu_pkg::*;

    localparam int PIPE_LAT  = 68;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 400;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    logic [4:0]      i_operation;
    logic [XLEN-1:0] i_operand_a;
    logic [XLEN-1:0] i_operand_b;
    logic            o_valid;
    logic            i_stall;
    logic [XLEN-1:0] o_result;

    logic [XLEN-1:0] result_q[$];
    int              n_err = 0;
    int              idle_cycles = 0;
    int              hold_req = 0;
    int              hold_done = 0;
    bit              rx_random;

    rv64im_integer_alu u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_operation(i_operation),
        .i_operand_a(i_operand_a),
        .i_operand_b(i_operand_b),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] sx32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] sdiv_calc(input logic [63:0] a, input logic [63:0] b,
                                              input bit rem);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic [63:0] r;
        if (b == 64'd0) return rem ? a : '1;
        if (a == {1'b1, 63'd0} && b == '1) return rem ? 64'd0 : a;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (rem) return a[63] ? -r : r;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] alu_result(input logic [4:0] op, input logic [63:0] a,
                                               input logic [63:0] b);
        logic [127:0] p;
        logic [63:0]  a32;
        logic [63:0]  b32;
        logic [63:0]  ua;
        logic [63:0]  ub;
        a32 = sx32(a);
        b32 = sx32(b);
        ua = {32'd0, a[31:0]};
        ub = {32'd0, b[31:0]};
        case (op)
            OP_ADD:    return a + b;
            OP_SUB:    return a - b;
            OP_AND:    return a & b;
            OP_OR:     return a | b;
            OP_XOR:    return a ^ b;
            OP_SLL:    return a << b[5:0];
            OP_SRL:    return a >> b[5:0];
            OP_SRA:    return $signed(a) >>> b[5:0];
            OP_SLT:    return {63'd0, $signed(a) < $signed(b)};
            OP_SLTU:   return {63'd0, a < b};
            OP_MUL:    return a * b;
            OP_MULH: begin
                p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
                return p[127:64];
            end
            OP_MULHSU: begin
                p = {{64{a[63]}}, a} * {64'd0, b};
                return p[127:64];
            end
            OP_MULHU: begin
                p = {64'd0, a} * {64'd0, b};
                return p[127:64];
            end
            OP_DIV:    return sdiv_calc(a, b, 1'b0);
            OP_DIVU:   return (b == 0) ? '1 : a / b;
            OP_REM:    return sdiv_calc(a, b, 1'b1);
            OP_REMU:   return (b == 0) ? a : a % b;
            OP_ADDW:   return sx32(a + b);
            OP_SUBW:   return sx32(a - b);
            OP_SLLW:   return sx32(ua << b[4:0]);
            OP_SRLW:   return sx32(ua >> b[4:0]);
            OP_SRAW:   return sx32($signed(a32) >>> b[4:0]);
            OP_MULW:   return sx32(ua * ub);
            OP_DIVW:   return sx32(sdiv_calc(a32, b32, 1'b0));
            OP_DIVUW:  return sx32((ub == 0) ? 64'hFFFF_FFFF : ua / ub);
            OP_REMW:   return sx32(sdiv_calc(a32, b32, 1'b1));
            OP_REMUW:  return sx32((ub == 0) ? ua : ua % ub);
            default:   return 64'd0;
        endcase
    endfunction

    // Drive one word, hold it until accepted.
    task automatic send_word(input logic [4:0] op, input logic [63:0] a, input logic [63:0] b);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_stall);
        result_q.push_back(alu_result(op, a, b));
        @(negedge i_clk);
    endtask

    task automatic idle_tx(input int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = '1;
            2: v = {1'b1, 63'd0};
            3: v = {1'b0, {63{1'b1}}};
            4: v = {{32{v[31]}}, v[31:0]};
            5: v = 64'($urandom_range(0, 70));
            6: v = {32'd0, 1'b1, 31'd0};
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_directed();
        logic [63:0] mn;
        logic [63:0] mn32;
        mn = {1'b1, 63'd0};
        mn32 = {{33{1'b1}}, 31'd0};
        send_word(OP_ADD,    '1, 64'd1);
        send_word(OP_SUB,    mn, 64'd1);
        send_word(OP_SLL,    64'd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_SRA,    mn, 64'd63);
        send_word(OP_SRL,    mn, 64'd127);
        send_word(OP_SLT,    mn, 64'd0);
        send_word(OP_SLTU,   mn, 64'd0);
        send_word(OP_MULH,   mn, mn);
        send_word(OP_MULHSU, '1, '1);
        send_word(OP_MULHU,  '1, '1);
        // divide by zero, signed overflow
        send_word(OP_DIV,    64'd5, 64'd0);
        send_word(OP_REM,    64'd5, 64'd0);
        send_word(OP_DIVU,   '1, 64'd0);
        send_word(OP_REMU,   '1, 64'd0);
        send_word(OP_DIV,    mn, '1);
        send_word(OP_REM,    mn, '1);
        send_word(OP_DIVW,   mn32, '1);
        send_word(OP_REMW,   mn32, '1);
        send_word(OP_DIVUW,  64'hABCD_0000_0000_0007, 64'hFFFF_FFFF_0000_0000);
        send_word(OP_REMUW,  64'hABCD_8000_0000_0007, 64'h1_0000_0000);
        send_word(OP_SLLW,   64'hFFFF_FFFF, 64'd63);
        send_word(OP_SRAW,   64'h8000_0000, 64'd33);
        send_word(OP_MULW,   '1, 64'h8000_0000);
        for (int op = 28; op < 32; op++) send_word(op[4:0], '1, '1);
        wait_drain();
    endtask

    task automatic test_random();
        int burst;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (burst == 0) begin
                idle_tx($urandom_range(0, 6));
                burst = $urandom_range(1, 30);
            end
            burst--;
            send_word(($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(0, 27)),
                      rand_operand(), rand_operand());
        end
        wait_drain();
    endtask

    // Receiver stops for a long stretch while the sender keeps offering words.
    task automatic test_backpressure();
        hold_req++;
        for (int i = 0; i < 120; i++)
            send_word(5'($urandom_range(0, 27)), rand_operand(), rand_operand());
        wait_drain();
    endtask

    initial begin
        int cnt;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_done) begin
                i_stall <= 1'b1;
                cnt = 0;
                while (cnt < 300) begin
                    @(negedge i_clk);
                    cnt++;
                end
                hold_done++;
                i_stall <= 1'b0;
            end else if (rx_random) begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, o_result);
                n_err++;
            end else begin
                if (o_result !== result_q[0]) begin
                    $display("%0t: result mismatch, expected %h actual %h",
                             $time, result_q[0], o_result);
                    n_err++;
                end
                void'(result_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        rx_random   = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = '0;
        i_operand_a = '0;
        i_operand_b = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        rx_random = 1'b1;
        test_random();
        test_backpressure();
        test_random();
        repeat (PIPE_LAT + 10) @(negedge i_clk);
        if (n_err == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
